### rtl/pi_speed_controller_top_assert.svh
// Assertion macros shared by the speed controller RTL.
`ifndef PI_SPEED_CONTROLLER_TOP_ASSERT_SVH
`define PI_SPEED_CONTROLLER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PISC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pisc assertion failed");
`define PISC_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pisc assertion failed");
`else
`define PISC_ASSERT(lbl, prop)
`define PISC_ASSERT_NORST(lbl, prop)
`endif
`endif

### rtl/pisc_pkg.sv
// Types and constants of the PI speed controller.
package pisc_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int PGAIN_W = 8;
  localparam int IGAIN_W = 8;
  localparam int ILIM_W  = 10;
  localparam int DLIM_W  = 11;
  localparam int TGT_W   = 8;
  localparam int SUM_W   = 11;

  // error is saturated to +/- ERR_SAT; beyond that both clamps saturate anyway
  localparam int ERR_W   = 22;
  localparam int ERR_SAT = 1 << 20;
  localparam int DRV_W   = 32;

  localparam logic [PGAIN_W-1:0] PGAIN_RST = 8'd30;
  localparam logic [IGAIN_W-1:0] IGAIN_RST = 8'd5;
  localparam logic [ILIM_W-1:0]  ILIM_RST  = 10'd204;
  localparam logic [DLIM_W-1:0]  DLIM_RST  = 11'd2047;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 8'd0,
    REG_INTEG_GAIN  = 8'd1,
    REG_INTEG_LIMIT = 8'd2,
    REG_DRIVE_LIMIT = 8'd3
  } pisc_reg_e;

  typedef struct packed {
    logic [PGAIN_W-1:0] prop_gain;
    logic [IGAIN_W-1:0] integ_gain;
    logic [ILIM_W-1:0]  integ_limit;
    logic [DLIM_W-1:0]  drive_limit;
  } pisc_cfg_t;

endpackage

### rtl/pisc_regs.sv
// Configuration register file of the PI speed controller.
module pisc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pisc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pisc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output pisc_pkg::pisc_cfg_t            cfg_o
);
  import pisc_pkg::*;

  pisc_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (pisc_reg_e'(cfg_index_i))
        REG_PROP_GAIN:   cfg_d.prop_gain   = cfg_data_i[PGAIN_W-1:0];
        REG_INTEG_GAIN:  cfg_d.integ_gain  = cfg_data_i[IGAIN_W-1:0];
        REG_INTEG_LIMIT: cfg_d.integ_limit = cfg_data_i[ILIM_W-1:0];
        REG_DRIVE_LIMIT: cfg_d.drive_limit = cfg_data_i[DLIM_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= PGAIN_RST;
      cfg_q.integ_gain  <= IGAIN_RST;
      cfg_q.integ_limit <= ILIM_RST;
      cfg_q.drive_limit <= DLIM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/pisc_integ.sv
// Speed measurement, error saturation and clamped integral stage.
`include "pi_speed_controller_top_assert.svh"
module pisc_integ #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [COUNT_WIDTH-1:0]            encoder_count_i,
  input  logic signed [pisc_pkg::TGT_W-1:0] target_speed_i,
  input  logic [pisc_pkg::ILIM_W-1:0]       integ_limit_i,
  output logic signed [pisc_pkg::ERR_W-1:0] err_o,
  output logic signed [pisc_pkg::SUM_W-1:0] sum_o
);
  import pisc_pkg::*;

  localparam int EXT_W = (COUNT_WIDTH + 1 > ERR_W + 1) ? COUNT_WIDTH + 1 : ERR_W + 1;
  localparam logic signed [EXT_W-1:0] SAT_POS = EXT_W'(ERR_SAT);
  localparam logic signed [EXT_W-1:0] SAT_NEG = -SAT_POS;
  localparam int ACC_W = ERR_W + 1;

  logic [COUNT_WIDTH-1:0]    last_count_q;
  logic signed [SUM_W-1:0]   error_sum_q, error_sum_d;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic signed [SUM_W-1:0]   sum_q;

  logic [COUNT_WIDTH-1:0]    diff;
  logic signed [EXT_W-1:0]   err_ext;
  logic signed [ACC_W-1:0]   acc, lim_pos, lim_neg;

  always_comb begin
    diff    = encoder_count_i - last_count_q;
    err_ext = EXT_W'(target_speed_i) - EXT_W'($signed(diff));
    if (err_ext > SAT_POS) begin
      err_d = ERR_W'(SAT_POS);
    end else if (err_ext < SAT_NEG) begin
      err_d = ERR_W'(SAT_NEG);
    end else begin
      err_d = ERR_W'(err_ext);
    end

    lim_pos = ACC_W'($signed({1'b0, integ_limit_i}));
    lim_neg = -lim_pos;
    acc     = ACC_W'(error_sum_q) + ACC_W'(err_d);
    if (acc > lim_pos) begin
      error_sum_d = SUM_W'(lim_pos);
    end else if (acc < lim_neg) begin
      error_sum_d = SUM_W'(lim_neg);
    end else begin
      error_sum_d = SUM_W'(acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      error_sum_q  <= '0;
    end else if (load_i) begin
      last_count_q <= encoder_count_i;
      error_sum_q  <= error_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_q <= err_d;
      sum_q <= error_sum_d;
    end
  end

  assign err_o = err_q;
  assign sum_o = sum_q;

  `PISC_ASSERT(a_sum_in_bound, load_i |=>
    (error_sum_q <= $signed({1'b0, $past(integ_limit_i)})) &&
    (error_sum_q >= -$signed({1'b0, $past(integ_limit_i)})))
  `PISC_ASSERT(a_sum_copy, load_i |=> (sum_q == error_sum_q))

endmodule

### rtl/pisc_drive.sv
// Gain multiply, drive clamp and magnitude/direction result register.
`include "pi_speed_controller_top_assert.svh"
module pisc_drive #(
  parameter int DUTY_BITS = 11
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  pisc_pkg::pisc_cfg_t               cfg_i,
  input  logic signed [pisc_pkg::ERR_W-1:0] err_i,
  input  logic signed [pisc_pkg::SUM_W-1:0] sum_i,
  output logic [DUTY_BITS-1:0]              duty_o,
  output logic                              reverse_o
);
  import pisc_pkg::*;

  localparam logic signed [DRV_W-1:0] DUTY_MAX = DRV_W'((1 << DUTY_BITS) - 1);

  logic signed [DRV_W-1:0] p_term, i_term, drive, lim, drive_c, mag;
  logic [DUTY_BITS-1:0]    duty_q;
  logic                    reverse_q;

  always_comb begin
    p_term = DRV_W'($signed({1'b0, cfg_i.prop_gain})) * DRV_W'(err_i);
    i_term = DRV_W'($signed({1'b0, cfg_i.integ_gain})) * DRV_W'(sum_i);
    drive  = p_term + i_term;
    lim    = DRV_W'($signed({1'b0, cfg_i.drive_limit}));
    if (lim > DUTY_MAX) begin
      lim = DUTY_MAX;
    end
    if (drive > lim) begin
      drive_c = lim;
    end else if (drive < -lim) begin
      drive_c = -lim;
    end else begin
      drive_c = drive;
    end
    mag = (drive_c > 0) ? drive_c : -drive_c;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      duty_q    <= DUTY_BITS'(mag);
      reverse_q <= (drive_c <= 0);
    end
  end

  assign duty_o    = duty_q;
  assign reverse_o = reverse_q;

  `PISC_ASSERT(a_zero_is_reverse, $past(load_i) && (duty_q == '0) |-> reverse_q)

endmodule

### rtl/pi_speed_controller_top.sv
// Top level of the PI speed controller with clamped integral.
// Each transaction is registered in the integral stage, then in the drive result register.
// Throughput: one transaction per cycle, stalls only on output backpressure.
// Config writes complete in the cycle they are presented.
// Reset: gains and limits take their defaults, count and integral clear.
`include "pi_speed_controller_top_assert.svh"
module pi_speed_controller_top #(
  parameter int COUNT_WIDTH = 32,
  parameter int DUTY_BITS   = 11
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [COUNT_WIDTH-1:0]            encoder_count_i,
  input  logic signed [pisc_pkg::TGT_W-1:0] target_speed_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [DUTY_BITS-1:0]              duty_o,
  output logic                              reverse_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pisc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pisc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pisc_pkg::*;

  pisc_cfg_t               cfg;
  logic signed [ERR_W-1:0] err;
  logic signed [SUM_W-1:0] sum;
  logic                    s1_valid_q, s1_valid_d;
  logic                    out_valid_q, out_valid_d;
  logic                    s1_adv, in_fire, out_load;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = s1_adv && s1_valid_q;

  always_comb begin
    s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  pisc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pisc_integ #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_integ (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (in_fire),
    .encoder_count_i (encoder_count_i),
    .target_speed_i  (target_speed_i),
    .integ_limit_i   (cfg.integ_limit),
    .err_o           (err),
    .sum_o           (sum)
  );

  pisc_drive #(
    .DUTY_BITS (DUTY_BITS)
  ) u_drive (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (out_load),
    .cfg_i     (cfg),
    .err_i     (err),
    .sum_i     (sum),
    .duty_o    (duty_o),
    .reverse_o (reverse_o)
  );

  `PISC_ASSERT(a_accept_fills_s1, in_fire |=> s1_valid_q)
  `PISC_ASSERT(a_s1_held_on_stall, s1_valid_q && !s1_adv |=> s1_valid_q)
  `PISC_ASSERT_NORST(a_stage_moves_out, rst_ni && $past(rst_ni) && $past(out_load) |-> out_valid_q)

endmodule

### verif/tb_pi_speed_controller_top.sv
// Self-checking testbench for the PI speed controller: random and directed ticks, gain changes.
module tb_pi_speed_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pisc_pkg::*;

  localparam int CNT_W    = 32;
  localparam int DUTY_W   = 11;
  localparam int DUTY_MAX = (1 << DUTY_W) - 1;
  localparam int MAX_MSGS = 40;

  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX_A = 8'd4;
  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX_B = 8'hFF;

  typedef struct {
    logic [CNT_W-1:0]        count;
    logic signed [TGT_W-1:0] target;
  } tick_t;

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              reverse;
  } drive_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [CNT_W-1:0]        encoder_count_i = '0;
  logic signed [TGT_W-1:0] target_speed_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [DUTY_W-1:0]       duty_o;
  logic                    reverse_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  tick_t  tick_q[$];
  drive_t drive_q[$];

  int unsigned ticks_sent = 0;
  int unsigned ticks_done = 0;
  int unsigned mismatches = 0;
  int unsigned idle_pct = 33;
  logic        in_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic [CNT_W-1:0] gen_count = '0;

  // predictor state
  pisc_cfg_t        model_cfg = '{PGAIN_RST, IGAIN_RST, ILIM_RST, DLIM_RST};
  logic [CNT_W-1:0] prev_count = '0;
  longint           integ_acc = 0;

  pi_speed_controller_top #(
    .COUNT_WIDTH (CNT_W),
    .DUTY_BITS   (DUTY_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .encoder_count_i (encoder_count_i),
    .target_speed_i  (target_speed_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .duty_o          (duty_o),
    .reverse_o       (reverse_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic drive_t predict_drive(input logic [CNT_W-1:0] count,
                                           input logic signed [TGT_W-1:0] tgt);
    logic [CNT_W-1:0] delta;
    longint speed, err, sum, drv, lim, ilim;
    drive_t res;
    delta = count - prev_count;
    speed = longint'($signed(delta));
    err   = longint'(tgt) - speed;
    ilim  = longint'(model_cfg.integ_limit);
    sum   = integ_acc + err;
    if (sum > ilim) sum = ilim;
    else if (sum < -ilim) sum = -ilim;
    integ_acc = sum;
    drv = longint'(model_cfg.integ_gain) * sum + longint'(model_cfg.prop_gain) * err;
    lim = longint'(model_cfg.drive_limit);
    if (lim > DUTY_MAX) lim = DUTY_MAX;
    if (drv > lim) drv = lim;
    else if (drv < -lim) drv = -lim;
    prev_count = count;
    if (drv > 0) begin
      res.duty    = DUTY_W'(drv);
      res.reverse = 1'b0;
    end else begin
      res.duty    = DUTY_W'(-drv);
      res.reverse = 1'b1;
    end
    return res;
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    tick_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (tick_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = tick_q.pop_front();
          in_valid_i      <= 1'b1;
          encoder_count_i <= nxt.count;
          target_speed_i  <= nxt.target;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // monitor: handshakes sampled on the rising edge
  always @(posedge clk_i) begin
    drive_t exp_drv;
    if (rst_ni) begin
      in_taken  <= in_valid_i && in_ready_o;
      cfg_taken <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_PROP_GAIN:   model_cfg.prop_gain   = cfg_data_i[PGAIN_W-1:0];
          REG_INTEG_GAIN:  model_cfg.integ_gain  = cfg_data_i[IGAIN_W-1:0];
          REG_INTEG_LIMIT: model_cfg.integ_limit = cfg_data_i[ILIM_W-1:0];
          REG_DRIVE_LIMIT: model_cfg.drive_limit = cfg_data_i[DLIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        drive_q.push_back(predict_drive(encoder_count_i, target_speed_i));
        ticks_done++;
      end
      if (out_valid_o && out_ready_i) begin
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_MSGS)
            $display("%t: unexpected result duty=%0d reverse=%0d", $time, duty_o, reverse_o);
        end else begin
          exp_drv = drive_q.pop_front();
          if (duty_o !== exp_drv.duty) begin
            mismatches++;
            if (mismatches <= MAX_MSGS)
              $display("%t: duty mismatch, expected %0d, actual %0d",
                       $time, exp_drv.duty, duty_o);
          end
          if (reverse_o !== exp_drv.reverse) begin
            mismatches++;
            if (mismatches <= MAX_MSGS)
              $display("%t: reverse mismatch, expected %0d, actual %0d",
                       $time, exp_drv.reverse, reverse_o);
          end
        end
      end
    end
  end

  task automatic add_tick(input logic [CNT_W-1:0] count, input logic signed [TGT_W-1:0] tgt);
    tick_t t;
    t.count  = count;
    t.target = tgt;
    tick_q.push_back(t);
    gen_count = count;
    ticks_sent++;
  endtask

  // mostly plausible motion, some noise and some large jumps
  task automatic add_random_tick();
    int sel, spd, tgt;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) tgt = $urandom_range(0, 255) - 128;
    else tgt = $urandom_range(0, 40) - 20;
    if (sel < 80) begin
      spd = tgt + $urandom_range(0, 8) - 4;
      add_tick(gen_count + CNT_W'(spd), TGT_W'(tgt));
    end else if (sel < 90) begin
      add_tick(CNT_W'($urandom()), TGT_W'($urandom()));
    end else begin
      add_tick(gen_count + CNT_W'($urandom()), TGT_W'(tgt));
    end
  endtask

  task automatic drain();
    do @(negedge clk_i); while (ticks_done != ticks_sent || drive_q.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  // unused upper data bits carry junk
  task automatic set_gains(input int pg, input int ig, input int il, input int dl);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    write_reg(REG_PROP_GAIN,   {junk[CFG_DATA_W-1:PGAIN_W], PGAIN_W'(pg)});
    junk = CFG_DATA_W'($urandom());
    write_reg(REG_INTEG_GAIN,  {junk[CFG_DATA_W-1:IGAIN_W], IGAIN_W'(ig)});
    junk = CFG_DATA_W'($urandom());
    write_reg(REG_INTEG_LIMIT, {junk[CFG_DATA_W-1:ILIM_W], ILIM_W'(il)});
    junk = CFG_DATA_W'($urandom());
    write_reg(REG_DRIVE_LIMIT, {junk[CFG_DATA_W-1:DLIM_W], DLIM_W'(dl)});
  endtask

  initial begin
    int gains [8][4];
    gains = '{'{30, 5, 204, 2047}, '{0, 0, 0, 0}, '{255, 255, 1023, 2047},
              '{1, 1, 1023, 100}, '{12, 3, 50, 2047}, '{0, 0, 0, 0},
              '{0, 0, 0, 0}, '{30, 5, 204, 1}};
    for (int p = 5; p < 7; p++) begin
      gains[p][0] = $urandom_range(0, 255);
      gains[p][1] = $urandom_range(0, 255);
      gains[p][2] = $urandom_range(0, 1023);
      gains[p][3] = $urandom_range(0, 2047);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero drive, setpoint extremes, count wrap and extreme speeds
    add_tick(32'h0000_0000, 8'sd0);
    add_tick(32'h0000_0000, 8'sd127);
    add_tick(32'h0000_0000, -8'sd128);
    add_tick(32'h7FFF_FFFF, 8'sd0);
    add_tick(32'h8000_0000, 8'sd0);
    add_tick(32'h7FFF_FFFF, 8'sd0);
    add_tick(32'hFFFF_FFFF, -8'sd128);
    add_tick(32'h7FFF_FFFF, 8'sd127);
    add_tick(32'hFFFF_FFFE, 8'sd0);
    add_tick(32'h0000_0001, 8'sd3);
    add_tick(32'h0000_0006, 8'sd5);
    for (int i = 0; i < 5; i++) add_tick(gen_count, 8'sd100);
    drain();
    // integral sits at its bound; lowering the bound must clamp on the next tick
    write_reg(REG_INTEG_LIMIT, 16'd10);
    write_reg(UNUSED_IDX_A, 16'hFFFF);
    write_reg(UNUSED_IDX_B, 16'h0000);
    add_tick(gen_count, 8'sd0);
    add_tick(gen_count - 32'd20, -8'sd20);
    add_tick(gen_count + 32'd7, 8'sd0);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_gains(gains[p][0], gains[p][1], gains[p][2], gains[p][3]);
      for (int c = 0; c < 2; c++) begin
        idle_pct = (p == 2 && c == 1) ? 0 : 33;
        for (int i = 0; i < 105; i++) add_random_tick();
        // sender holds off until every result is back
        drain();
      end
    end
    idle_pct = 33;

    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
